// File: rtl/core/dpf_pkg.sv
`timescale 1ns / 1ps

package dpf_pkg;

    // field widths
    localparam int SEP_W  = 32;
    localparam int DIST_W = 31;
    localparam int ACC_W  = 48;
    localparam int WORD_W = 64;

    // reset value of the scale register, 1.0 in Q.24
    localparam logic [DIST_W-1:0] FS_RESET = 31'd16777216;

    // accumulator saturation bounds
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // request to the shared multiplier
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mul_req;

    // request to the shared divider: (hi:lo) / den
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] den;
    } t_div_req;

endpackage

// File: rtl/core/dpf_mul.sv
`timescale 1ns / 1ps

module dpf_mul import dpf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mul_req              i_req,
    output logic                  o_done,
    output logic [2*WORD_W-1:0]   o_prod
);

    localparam int CHUNK = 16;
    localparam int STEPS = WORD_W / CHUNK;

    logic [WORD_W-1:0]          r_a;
    logic [WORD_W-1:0]          r_b;
    logic [2*WORD_W-1:0]        r_acc;
    logic [$clog2(STEPS)-1:0]   r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [WORD_W+CHUNK-1:0]    w_part;

    // one 64x16 partial product per cycle, top chunk of b first
    assign w_part = (WORD_W+CHUNK)'(r_a) * (WORD_W+CHUNK)'(r_b[WORD_W-1 -: CHUNK]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= (r_acc << CHUNK) + (2*WORD_W)'(w_part);
                r_b   <= r_b << CHUNK;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(STEPS))'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: rtl/core/dpf_div.sv
`timescale 1ns / 1ps

module dpf_div import dpf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_req            i_req,
    output logic                o_done,
    output logic [WORD_W-1:0]   o_quot
);

    logic [WORD_W-1:0]          r_rem;
    logic [WORD_W-1:0]          r_lo;
    logic [WORD_W-1:0]          r_den;
    logic [WORD_W-1:0]          r_q;
    logic                       r_sat;
    logic [$clog2(WORD_W)-1:0]  r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [WORD_W-1:0]          w_sh;
    logic                       w_ge;

    // restoring step, one quotient bit per cycle
    assign w_sh = {r_rem[WORD_W-2:0], r_lo[WORD_W-1]};
    assign w_ge = r_rem[WORD_W-1] | (w_sh >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.hi;
                r_lo   <= i_req.lo;
                r_den  <= i_req.den;
                r_q    <= '0;
                r_sat  <= (i_req.hi >= i_req.den);
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_sh - r_den) : w_sh;
                r_lo  <= r_lo << 1;
                r_q   <= {r_q[WORD_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(WORD_W))'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient of 2^64 or more saturates
    assign o_done = r_done;
    assign o_quot = r_sat ? {WORD_W{1'b1}} : r_q;

endmodule

// File: rtl/core/dipole_pair_force_accumulate.sv
`timescale 1ns / 1ps

// Dipole-dipole pair force accumulator. Each input transfer is one particle
// pair (separation, contact distance, both moments, active flag in tuser,
// last neighbor in tlast). The pair force is added to a saturating Q16.32
// accumulator, and on the last pair the total is sent as one output transfer
// and the accumulator clears. All products run on one shared 64x16 multiplier
// and all quotients on one restoring divider (one bit per cycle), stepped by
// a sequencer; the squared length comes first, then a 32-step square root in
// the sequencer's own logic. Nine 64-step divisions dominate an active pair;
// an inactive or zero-separation pair skips from the square root to the end.
// The block takes no new pair while one is in work; a finished total waits in
// the output register, and the next last pair waits until it has been taken.

module dipole_pair_force_accumulate import dpf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [30:0]     i_cfg_wdata,     // force_scale
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // sep_x, sep_y, sep_z, contact_dist, moment_i_x/y/z, moment_j_x/y/z, pad
    input  logic [319:0]    s_axis_tdata,
    input  logic            s_axis_tuser,    // pair_active
    input  logic            s_axis_tlast,    // last_pair
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [143:0]    m_axis_tdata     // force_x, force_y, force_z
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROOT, S_UDIV, S_DOT, S_AB, S_DSQ,
        S_VMUL, S_NMUL, S_Q1, S_Q2, S_FIN
    } t_state;

    t_state                     r_state;
    logic                       r_busy;
    logic [1:0]                 r_k;
    logic [1:0]                 r_j;
    logic [DIST_W-1:0]          r_fs;

    logic signed [SEP_W-1:0]    r_sep [3];
    logic signed [SEP_W-1:0]    r_mi  [3];
    logic signed [SEP_W-1:0]    r_mj  [3];
    logic [DIST_W-1:0]          r_contact;
    logic                       r_active;
    logic                       r_last;

    logic [WORD_W-1:0]          r_x;
    logic [WORD_W-1:0]          r_res;
    logic [WORD_W-1:0]          r_one;
    logic [SEP_W-1:0]           r_root;
    logic signed [WORD_W-1:0]   r_u [3];
    logic signed [WORD_W-1:0]   r_sa;
    logic signed [WORD_W-1:0]   r_sb;
    logic signed [WORD_W-1:0]   r_c;
    logic signed [WORD_W-1:0]   r_t;
    logic [WORD_W-1:0]          r_d;
    logic signed [WORD_W-1:0]   r_v;
    logic [WORD_W-1:0]          r_q1;

    logic signed [ACC_W-1:0]    r_acc [3];
    logic [ACC_W-1:0]           r_out [3];
    logic                       r_ovalid;

    t_mul_req                   w_mreq;
    t_div_req                   w_dreq;
    logic                       w_mdone;
    logic [2*WORD_W-1:0]        w_mprod;
    logic                       w_ddone;
    logic [WORD_W-1:0]          w_dquot;

    logic signed [WORD_W-1:0]   w_a16;
    logic signed [WORD_W-1:0]   w_b16;
    logic signed [WORD_W-1:0]   w_p;
    logic [WORD_W-1:0]          w_rsum;
    logic                       w_rge;
    logic [WORD_W-1:0]          n_res;
    logic [SEP_W-1:0]           w_reff;
    logic [WORD_W-1:0]          w_mag;
    logic [SEP_W-1:0]           w_sabs;
    logic                       w_big;
    logic [ACC_W-1:0]           w_term;
    logic [ACC_W:0]             w_sum;
    logic [ACC_W-1:0]           w_sat;
    logic                       w_accept;
    logic                       w_emit;

    // shared units
    dpf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_prod  (w_mprod)
    );

    dpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_done  (w_ddone),
        .o_quot  (w_dquot)
    );

    // derived values
    assign w_a16  = r_sa >>> 38;
    assign w_b16  = r_sb >>> 38;
    assign w_p    = $signed(w_mprod[WORD_W-1:0]);
    assign w_rsum = r_res + r_one;
    assign w_rge  = (r_x >= w_rsum);
    assign n_res  = w_rge ? ((r_res >> 1) + r_one) : (r_res >> 1);
    assign w_reff = (r_root < {1'b0, r_contact}) ? {1'b0, r_contact} : r_root;
    assign w_mag  = r_v[WORD_W-1] ? (~r_v + 1'b1) : r_v;
    assign w_sabs = r_sep[r_k][SEP_W-1] ? (~r_sep[r_k] + 1'b1) : r_sep[r_k];

    // saturated pair term and saturated accumulate
    assign w_big  = |w_dquot[WORD_W-1:ACC_W-1];
    always_comb begin
        if (r_v[WORD_W-1]) begin
            w_term = w_big ? ACC_MIN : (~w_dquot[ACC_W-1:0] + 1'b1);
        end else begin
            w_term = w_big ? ACC_MAX : w_dquot[ACC_W-1:0];
        end
        w_sum = {r_acc[r_k][ACC_W-1], r_acc[r_k]} + {w_term[ACC_W-1], w_term};
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_sat = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            w_sat = w_sum[ACC_W-1:0];
        end
    end

    // multiplier operand select
    always_comb begin
        w_mreq = '0;
        unique case (r_state)
            S_SQ: begin
                w_mreq.a = {{32{r_sep[r_k][31]}}, r_sep[r_k]};
                w_mreq.b = {{32{r_sep[r_k][31]}}, r_sep[r_k]};
            end
            S_DOT: begin
                w_mreq.a = (r_j == 2'd1) ? {{32{r_mj[r_k][31]}}, r_mj[r_k]}
                                         : {{32{r_mi[r_k][31]}}, r_mi[r_k]};
                w_mreq.b = (r_j == 2'd2) ? {{32{r_mj[r_k][31]}}, r_mj[r_k]} : r_u[r_k];
            end
            S_AB: begin
                w_mreq.a = w_a16;
                w_mreq.b = w_b16;
            end
            S_DSQ: begin
                w_mreq.a = {32'd0, w_reff};
                w_mreq.b = {32'd0, w_reff};
            end
            S_VMUL: begin
                if (r_j == 2'd0) begin
                    w_mreq.a = w_a16;
                    w_mreq.b = {{32{r_mj[r_k][31]}}, r_mj[r_k]};
                end else if (r_j == 2'd1) begin
                    w_mreq.a = w_b16;
                    w_mreq.b = {{32{r_mi[r_k][31]}}, r_mi[r_k]};
                end else begin
                    w_mreq.a = r_t;
                    w_mreq.b = r_u[r_k] >>> 14;
                end
            end
            S_NMUL: begin
                w_mreq.a = w_mag;
                w_mreq.b = {33'd0, r_fs};
            end
            default: ;
        endcase
        w_mreq.start = !r_busy && (r_state == S_SQ || r_state == S_DOT ||
                       r_state == S_AB || r_state == S_DSQ ||
                       r_state == S_VMUL || r_state == S_NMUL);
    end

    // divider operand select
    always_comb begin
        w_dreq = '0;
        unique case (r_state)
            S_UDIV: begin
                w_dreq.lo  = {2'd0, w_sabs, 30'd0};
                w_dreq.den = {32'd0, r_root};
            end
            S_Q1: begin
                w_dreq.hi  = w_mprod[103:40];
                w_dreq.lo  = {w_mprod[39:0], 24'd0};
                w_dreq.den = r_d;
            end
            S_Q2: begin
                w_dreq.hi  = {16'd0, r_q1[63:16]};
                w_dreq.lo  = {r_q1[15:0], 48'd0};
                w_dreq.den = r_d;
            end
            default: ;
        endcase
        w_dreq.start = !r_busy && (r_state == S_UDIV || r_state == S_Q1 ||
                       r_state == S_Q2);
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // total moves to the output register on the last pair
    assign w_emit = (r_state == S_FIN) && r_last && (!r_ovalid || m_axis_tready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_k      <= '0;
            r_j      <= '0;
            r_fs     <= FS_RESET;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_fs <= i_cfg_wdata;
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_mreq.start || w_dreq.start) begin
                r_busy <= 1'b1;
            end
            if (w_mdone || w_ddone) begin
                r_busy <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_sep[0]  <= s_axis_tdata[31:0];
                        r_sep[1]  <= s_axis_tdata[63:32];
                        r_sep[2]  <= s_axis_tdata[95:64];
                        r_contact <= s_axis_tdata[126:96];
                        r_mi[0]   <= s_axis_tdata[158:127];
                        r_mi[1]   <= s_axis_tdata[190:159];
                        r_mi[2]   <= s_axis_tdata[222:191];
                        r_mj[0]   <= s_axis_tdata[254:223];
                        r_mj[1]   <= s_axis_tdata[286:255];
                        r_mj[2]   <= s_axis_tdata[318:287];
                        r_active  <= s_axis_tuser;
                        r_last    <= s_axis_tlast;
                        r_x       <= '0;
                        r_sa      <= '0;
                        r_sb      <= '0;
                        r_c       <= '0;
                        r_k       <= '0;
                        r_j       <= '0;
                        r_state   <= S_SQ;
                    end
                end
                // squared length, wrapping at 64 bits
                S_SQ: begin
                    if (w_mdone) begin
                        r_x <= r_x + w_mprod[WORD_W-1:0];
                        if (r_k == 2'd2) begin
                            r_k     <= '0;
                            r_res   <= '0;
                            r_one   <= {2'b01, 62'd0};
                            r_state <= S_ROOT;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                // integer square root, two radicand bits per step
                S_ROOT: begin
                    if (w_rge) begin
                        r_x <= r_x - w_rsum;
                    end
                    r_res <= n_res;
                    r_one <= r_one >> 2;
                    if (r_one == 64'd1) begin
                        r_root  <= n_res[SEP_W-1:0];
                        r_state <= (r_active && n_res != '0) ? S_UDIV : S_FIN;
                    end
                end
                // unit vector in Q.30, truncated toward zero
                S_UDIV: begin
                    if (w_ddone) begin
                        r_u[r_k] <= r_sep[r_k][SEP_W-1] ? (~w_dquot + 1'b1) : w_dquot;
                        if (r_k == 2'd2) begin
                            r_k     <= '0;
                            r_j     <= '0;
                            r_state <= S_DOT;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                // mu_i.u, mu_j.u and mu_i.mu_j
                S_DOT: begin
                    if (w_mdone) begin
                        unique case (r_j)
                            2'd0:    r_sa <= r_sa + w_p;
                            2'd1:    r_sb <= r_sb + w_p;
                            default: r_c  <= r_c + (w_p >>> 32);
                        endcase
                        if (r_j == 2'd2) begin
                            r_j <= '0;
                            if (r_k == 2'd2) begin
                                r_k     <= '0;
                                r_state <= S_AB;
                            end else begin
                                r_k <= r_k + 1'b1;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_AB: begin
                    if (w_mdone) begin
                        r_t     <= r_c - (((w_p >>> 16) <<< 2) + (w_p >>> 16));
                        r_state <= S_DSQ;
                    end
                end
                S_DSQ: begin
                    if (w_mdone) begin
                        r_d     <= w_mprod[WORD_W-1:0];
                        r_v     <= '0;
                        r_k     <= '0;
                        r_j     <= '0;
                        r_state <= S_VMUL;
                    end
                end
                // vector term of one axis in Q.32
                S_VMUL: begin
                    if (w_mdone) begin
                        if (r_j == 2'd2) begin
                            r_v     <= r_v + w_p;
                            r_j     <= '0;
                            r_state <= S_NMUL;
                        end else begin
                            r_v <= r_v + (w_p >>> 8);
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_NMUL: begin
                    if (w_mdone) begin
                        r_state <= S_Q1;
                    end
                end
                S_Q1: begin
                    if (w_ddone) begin
                        r_q1    <= w_dquot;
                        r_state <= S_Q2;
                    end
                end
                S_Q2: begin
                    if (w_ddone) begin
                        r_acc[r_k] <= w_sat;
                        r_v        <= '0;
                        if (r_k == 2'd2) begin
                            r_k     <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_VMUL;
                        end
                    end
                end
                // hand the total to the output register on the last pair
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (w_emit) begin
                        for (int i = 0; i < 3; i++) begin
                            r_out[i] <= r_acc[i];
                            r_acc[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};

endmodule

// File: sim/dipole_pair_force_accumulate_tb.sv
`timescale 1ns / 1ps

module dipole_pair_force_accumulate_tb;
    import dpf_pkg::*;

    localparam int     CYC_LIMIT = 3000000;
    localparam int     DRAIN_WAIT = 1000;
    localparam longint F_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint F_MIN = -F_MAX - 1;

    typedef struct {
        logic signed [SEP_W-1:0]  sep[3];
        logic        [DIST_W-1:0] contact;
        logic signed [SEP_W-1:0]  mom_i[3];
        logic signed [SEP_W-1:0]  mom_j[3];
        logic                     active;
        logic                     last;
    } t_pair;

    typedef struct {
        logic [ACC_W-1:0] f[3];
    } t_force;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [30:0]   i_cfg_wdata;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [319:0]  s_axis_tdata;
    logic          s_axis_tuser;
    logic          s_axis_tlast;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [143:0]  m_axis_tdata;

    t_pair               pending_pairs[$];
    t_force              expected_forces[$];
    t_pair               cur_pair;
    longint              force_sum[3];
    logic [DIST_W-1:0]   scale_reg;
    int                  errors;
    int                  cycles;
    int                  pairs_sent;
    int                  forces_seen;
    int                  burst_left;
    int                  gap_left;
    int                  stall_mode;

    dipole_pair_force_accumulate i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned one;
        res = 0;
        one = 64'd1 << 62;
        while (one > x) one = one >> 2;
        while (one != 0) begin
            if (x >= res + one) begin
                x = x - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    // quotient saturated to 64 bits
    function automatic longint unsigned sat_div(logic [127:0] num, longint unsigned den);
        logic [127:0] q;
        q = num / {64'd0, den};
        return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
    endfunction

    // v * scale / d^2, signed, saturated to the accumulator range
    function automatic longint scale_by_dist(longint v, longint unsigned d);
        longint unsigned mag;
        longint unsigned q1;
        longint unsigned q2;
        logic [127:0]    num;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        num = ({64'd0, mag} * {97'd0, scale_reg}) << 24;
        q1 = sat_div(num, d);
        num = {16'd0, q1, 48'd0};
        q2 = sat_div(num, d);
        if (v < 0) return (q2 >= (64'd1 << 47)) ? F_MIN : -longint'(q2);
        return (q2 > longint'(F_MAX)) ? F_MAX : longint'(q2);
    endfunction

    // pair force into the running sum, total queued on the last pair
    task automatic accumulate_pair(t_pair p);
        longint          s[3], mi[3], mj[3], u30[3];
        longint unsigned sq, r, reff, d;
        longint          sa, sb, c16, a16, b16, t16, v, total;
        t_force          res;
        sq = 0;
        for (int k = 0; k < 3; k++) begin
            s[k] = longint'(p.sep[k]);
            mi[k] = longint'(p.mom_i[k]);
            mj[k] = longint'(p.mom_j[k]);
            sq += longint'(s[k] * s[k]);
        end
        r = int_sqrt(sq);
        if (p.active && r != 0) begin
            sa = 0;
            sb = 0;
            c16 = 0;
            for (int k = 0; k < 3; k++) begin
                u30[k] = (s[k] <<< 30) / longint'(r);
                sa += mi[k] * u30[k];
                sb += mj[k] * u30[k];
                c16 += (mi[k] * mj[k]) >>> 32;
            end
            a16 = sa >>> 38;
            b16 = sb >>> 38;
            t16 = c16 - 5 * ((a16 * b16) >>> 16);
            reff = (r < {33'd0, p.contact}) ? {33'd0, p.contact} : r;
            d = reff * reff;
            for (int k = 0; k < 3; k++) begin
                v = ((a16 * mj[k]) >>> 8) + ((b16 * mi[k]) >>> 8) + t16 * (u30[k] >>> 14);
                total = force_sum[k] + scale_by_dist(v, d);
                if (total > F_MAX) total = F_MAX;
                if (total < F_MIN) total = F_MIN;
                force_sum[k] = total;
            end
        end
        if (p.last) begin
            for (int k = 0; k < 3; k++) begin
                res.f[k] = force_sum[k][ACC_W-1:0];
                force_sum[k] = 0;
            end
            expected_forces.push_back(res);
        end
    endtask

    function automatic logic [319:0] pack_pair(t_pair p);
        return {1'b0, p.mom_j[2], p.mom_j[1], p.mom_j[0], p.mom_i[2], p.mom_i[1],
                p.mom_i[0], p.contact, p.sep[2], p.sep[1], p.sep[0]};
    endfunction

    // full range or moderate magnitude, so forces do not all saturate
    function automatic logic [31:0] rand_word(bit full, int mag_bits);
        if (full) return $urandom;
        return 32'($signed($urandom_range(0, (1 << (mag_bits + 1)) - 1)) - (1 << mag_bits));
    endfunction

    function automatic t_pair rand_pair(bit full, logic last);
        t_pair p;
        for (int k = 0; k < 3; k++) begin
            p.sep[k] = rand_word(full, $urandom_range(18, 26));
            p.mom_i[k] = rand_word(full, $urandom_range(20, 26));
            p.mom_j[k] = rand_word(full, $urandom_range(20, 26));
        end
        p.contact = full ? 31'($urandom) : 31'($urandom_range(0, 1 << 26));
        p.active = ($urandom_range(0, 7) != 0);
        p.last = last;
        return p;
    endfunction

    function automatic t_pair fixed_pair(logic [31:0] sv, logic [30:0] cd, logic [31:0] mv,
                                         logic act, logic last);
        t_pair p;
        for (int k = 0; k < 3; k++) begin
            p.sep[k] = sv;
            p.mom_i[k] = mv;
            p.mom_j[k] = ~mv;
        end
        p.contact = cd;
        p.active = act;
        p.last = last;
        return p;
    endfunction

    // random runs of neighbors, each closed by a last pair, mixed with noise pairs
    task automatic queue_runs(int n_pairs);
        int run_len;
        int done;
        done = 0;
        while (done < n_pairs) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: isolated full-range pairs with random last flag
                pending_pairs.push_back(rand_pair(1'b1, 1'($urandom)));
                done++;
            end else begin
                run_len = $urandom_range(1, 6);
                for (int i = 0; i < run_len; i++)
                    pending_pairs.push_back(rand_pair(($urandom_range(0, 5) == 0),
                                                      (i == run_len - 1)));
                done += run_len;
            end
        end
    endtask

    task automatic wait_idle();
        wait (pending_pairs.size() == 0 && !s_axis_tvalid && expected_forces.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [30:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        scale_reg = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sender: bursts with gaps, pairs predicted on transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                accumulate_pair(cur_pair);
                pairs_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0 || pending_pairs.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    cur_pair = pending_pairs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pack_pair(cur_pair);
                    s_axis_tuser <= cur_pair.active;
                    s_axis_tlast <= cur_pair.last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
        end
    end

    // receiver: stall pattern changes mode now and then, result checks
    always @(posedge i_clk) begin
        t_force exp_f;
        logic [ACC_W-1:0] got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                forces_seen++;
                if (expected_forces.size() == 0) begin
                    $display("%0t: unexpected force transfer, actual %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    exp_f = expected_forces.pop_front();
                    for (int k = 0; k < 3; k++) begin
                        got = m_axis_tdata[k*ACC_W +: ACC_W];
                        if (got !== exp_f.f[k]) begin
                            $display("%0t: force[%0d] expected %h actual %h",
                                     $time, k, exp_f.f[k], got);
                            errors++;
                        end
                    end
                end
            end
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 0);
                2: m_axis_tready <= ($urandom_range(0, 9) == 0);
                default: m_axis_tready <= (cycles % 64 < 8);
            endcase
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus and phases
    initial begin
        errors = 0;
        cycles = 0;
        pairs_sent = 0;
        forces_seen = 0;
        burst_left = 1;
        gap_left = 0;
        stall_mode = 0;
        for (int k = 0; k < 3; k++) force_sum[k] = 0;
        scale_reg = FS_RESET;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero separation, inactive, contact cases
        pending_pairs.push_back(fixed_pair(32'h0100_0000, 31'd0, 32'h0100_0000, 1'b1, 1'b1));
        pending_pairs.push_back(fixed_pair(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           1'b1, 1'b1));
        pending_pairs.push_back(fixed_pair(32'h8000_0000, 31'd0, 32'h8000_0000, 1'b1, 1'b1));
        pending_pairs.push_back(fixed_pair(32'h0, 31'h0100_0000, 32'h0100_0000, 1'b1, 1'b1));
        pending_pairs.push_back(fixed_pair(32'h0000_4000, 31'h0200_0000, 32'h0080_0000,
                                           1'b1, 1'b0));
        pending_pairs.push_back(fixed_pair(32'hFF00_0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                                           1'b1, 1'b0));
        pending_pairs.push_back(fixed_pair(32'h0100_0000, 31'd1, 32'h7FFF_FFFF, 1'b0, 1'b1));
        pending_pairs.push_back(fixed_pair(32'h0000_0001, 31'd0, 32'h8000_0000, 1'b1, 1'b0));
        pending_pairs.push_back(fixed_pair(32'h0000_0001, 31'd0, 32'h7FFF_FFFF, 1'b1, 1'b1));
        pending_pairs.push_back(fixed_pair(32'h0080_0000, 31'h0400_0000, 32'h0400_0000,
                                           1'b1, 1'b1));
        pending_pairs.push_back(fixed_pair(32'h0, 31'd0, 32'h0, 1'b0, 1'b1));
        for (int i = 0; i < 4; i++)
            pending_pairs.push_back(fixed_pair(32'h7FFF_FFFF, 31'd0, 32'h7FFF_FFFF, 1'b1,
                                               (i == 3)));
        queue_runs(60);
        wait_idle();

        // sender holds off until every total has come back, then continues
        queue_runs(60);
        wait_idle();

        write_scale(31'd0);
        queue_runs(40);
        wait_idle();

        write_scale(31'h7FFF_FFFF);
        queue_runs(80);
        wait_idle();

        write_scale(31'($urandom_range(1, 32'h0400_0000)));
        queue_runs(120);
        wait_idle();

        write_scale(31'd1);
        queue_runs(30);
        wait_idle();

        write_scale(FS_RESET);
        queue_runs(110);
        wait_idle();

        $display("pairs sent %0d, force totals checked %0d, mismatches %0d",
                 pairs_sent, forces_seen, errors);
        $display("scale settings: reset, zero, max, random, one; contact and zero-r cases");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/dpf_pkg.sv
rtl/core/dpf_mul.sv
rtl/core/dpf_div.sv
rtl/core/dipole_pair_force_accumulate.sv
sim/dipole_pair_force_accumulate_tb.sv
